### rtl/scsp_pkg.sv
// Shared types and constants for the serial command stepper positioner.
// Holds control word layout, op and jump codes, event codes and characters.
// No dependencies.
`default_nettype none

package scsp_pkg;

	localparam int CMD_DEPTH_DEF = 10;

	// datapath operations
	localparam logic [3:0] OP_IDLE   = 4'd0;
	localparam logic [3:0] OP_NOP    = 4'd1;
	localparam logic [3:0] OP_SELCMD = 4'd2;
	localparam logic [3:0] OP_SKIP   = 4'd3;
	localparam logic [3:0] OP_SIGN   = 4'd4;
	localparam logic [3:0] OP_DIGIT  = 4'd5;
	localparam logic [3:0] OP_FINISH = 4'd6;
	localparam logic [3:0] OP_MULT   = 4'd7;
	localparam logic [3:0] OP_EMIT   = 4'd8;
	localparam logic [3:0] OP_ERR    = 4'd9;
	localparam logic [3:0] OP_TICK   = 4'd10;
	localparam logic [3:0] OP_COLON  = 4'd11;
	localparam logic [3:0] OP_STORE  = 4'd12;

	// jump conditions
	localparam logic [3:0] C_NEVER  = 4'd0;
	localparam logic [3:0] C_ALWAYS = 4'd1;
	localparam logic [3:0] C_TICK   = 4'd2;
	localparam logic [3:0] C_COLON  = 4'd3;
	localparam logic [3:0] C_NOTCR  = 4'd4;
	localparam logic [3:0] C_END    = 4'd5;
	localparam logic [3:0] C_NOTPT  = 4'd6;
	localparam logic [3:0] C_BLANK  = 4'd7;
	localparam logic [3:0] C_DIGIT  = 4'd8;
	localparam logic [3:0] C_BUSY   = 4'd9;

	localparam int PC_W = 5;

	// result kinds
	localparam logic [1:0] EV_TARGET = 2'd0;
	localparam logic [1:0] EV_PERIOD = 2'd1;
	localparam logic [1:0] EV_ERROR  = 2'd2;
	localparam logic [1:0] EV_TICK   = 2'd3;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;

	localparam logic [15:0] PERIOD_RST = 16'd1000;
	localparam logic [12:0] CMP_SCALE  = 13'd6250;

	typedef struct packed {
		logic [3:0]      op;
		logic [3:0]      cond;
		logic [PC_W-1:0] target;
	} scsp_ctrl_t;

	typedef struct packed {
		logic tick;
		logic colon;
		logic not_cr;
		logic at_end;
		logic not_pt;
		logic blank;
		logic digit;
		logic busy;
	} scsp_flags_t;

endpackage

`default_nettype wire

### rtl/scsp_sequencer.sv
// Microprogram sequencer: step counter, control store and jump logic.
// Depends on scsp_pkg for control word layout and op/condition codes.
`default_nettype none

module scsp_sequencer
	import scsp_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  scsp_flags_t flags,
	output scsp_ctrl_t  ctrl
);

	localparam logic [PC_W-1:0] A_IDLE   = 5'd0;
	localparam logic [PC_W-1:0] A_ENTRY  = 5'd1;
	localparam logic [PC_W-1:0] A_SKIP   = 5'd7;
	localparam logic [PC_W-1:0] A_DIGIT  = 5'd9;
	localparam logic [PC_W-1:0] A_EMIT   = 5'd12;
	localparam logic [PC_W-1:0] A_ERR    = 5'd14;
	localparam logic [PC_W-1:0] A_TICK   = 5'd15;
	localparam logic [PC_W-1:0] A_COLON  = 5'd16;
	localparam logic [PC_W-1:0] A_STORE  = 5'd17;

	function automatic scsp_ctrl_t rom_word(input logic [PC_W-1:0] a);
		scsp_ctrl_t w;
		w = '{op: OP_IDLE, cond: C_ALWAYS, target: A_IDLE};
		case (a)
			5'd0:  w = '{op: OP_IDLE,   cond: C_ALWAYS, target: A_IDLE};
			5'd1:  w = '{op: OP_NOP,    cond: C_TICK,   target: A_TICK};
			5'd2:  w = '{op: OP_NOP,    cond: C_COLON,  target: A_COLON};
			5'd3:  w = '{op: OP_NOP,    cond: C_NOTCR,  target: A_STORE};
			// carriage return: run the stored command
			5'd4:  w = '{op: OP_NOP,    cond: C_END,    target: A_ERR};
			5'd5:  w = '{op: OP_SELCMD, cond: C_NOTPT,  target: A_ERR};
			5'd6:  w = '{op: OP_NOP,    cond: C_END,    target: A_ERR};
			5'd7:  w = '{op: OP_SKIP,   cond: C_BLANK,  target: A_SKIP};
			5'd8:  w = '{op: OP_SIGN,   cond: C_NEVER,  target: A_IDLE};
			5'd9:  w = '{op: OP_DIGIT,  cond: C_DIGIT,  target: A_DIGIT};
			5'd10: w = '{op: OP_FINISH, cond: C_NEVER,  target: A_IDLE};
			5'd11: w = '{op: OP_MULT,   cond: C_NEVER,  target: A_IDLE};
			5'd12: w = '{op: OP_EMIT,   cond: C_BUSY,   target: A_EMIT};
			5'd13: w = '{op: OP_NOP,    cond: C_ALWAYS, target: A_IDLE};
			5'd14: w = '{op: OP_ERR,    cond: C_ALWAYS, target: A_EMIT};
			5'd15: w = '{op: OP_TICK,   cond: C_ALWAYS, target: A_EMIT};
			5'd16: w = '{op: OP_COLON,  cond: C_ALWAYS, target: A_IDLE};
			5'd17: w = '{op: OP_STORE,  cond: C_ALWAYS, target: A_IDLE};
			default: w = '{op: OP_IDLE, cond: C_ALWAYS, target: A_IDLE};
		endcase
		return w;
	endfunction

	logic [PC_W-1:0] pc_q;
	logic            take;

	assign ctrl = rom_word(pc_q);

	always_comb begin
		case (ctrl.cond)
			C_NEVER:  take = 1'b0;
			C_ALWAYS: take = 1'b1;
			C_TICK:   take = flags.tick;
			C_COLON:  take = flags.colon;
			C_NOTCR:  take = flags.not_cr;
			C_END:    take = flags.at_end;
			C_NOTPT:  take = flags.not_pt;
			C_BLANK:  take = flags.blank;
			C_DIGIT:  take = flags.digit;
			C_BUSY:   take = flags.busy;
			default:  take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= A_IDLE;
		end else if (start) begin
			pc_q <= A_ENTRY;
		end else if (take) begin
			pc_q <= ctrl.target;
		end else begin
			pc_q <= pc_q + 5'd1;
		end
	end

	a_start_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ctrl.op == OP_IDLE)
		else $error("item accepted while sequencer busy");

	a_entry_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> pc_q == A_ENTRY)
		else $error("sequencer did not enter program after accept");

	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_EMIT && flags.busy) |=> ctrl.op == OP_EMIT)
		else $error("emit step left while output full");

endmodule

`default_nettype wire

### rtl/scsp_datapath.sv
// Datapath: item latch, command buffer, number parser registers, motion
// state and output register. Driven by the control word of scsp_sequencer.
// Depends on scsp_pkg.
`default_nettype none

module scsp_datapath
	import scsp_pkg::*;
#(
	parameter int CMD_DEPTH = CMD_DEPTH_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  wire         in_func,
	input  wire  [7:0]  in_byte,
	input  scsp_ctrl_t  ctrl,
	output scsp_flags_t flags,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [1:0]  out_kind,
	output logic [71:0] out_data
);

	localparam int IDX_W = $clog2(CMD_DEPTH + 1);

	logic [7:0]       buf_q [CMD_DEPTH];
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] rd_q;
	logic             func_q;
	logic [7:0]       byte_q;
	logic [15:0]      acc_q;
	logic             neg_q;
	logic             is_t_q;
	logic [15:0]      val_q;
	logic [15:0]      cmp_q;
	logic [1:0]       ev_q;
	logic             moved_q;
	logic [15:0]      tgt_q;
	logic [15:0]      cur_q;
	logic [15:0]      period_q;
	logic             step_q;
	logic             dir_q;

	logic             out_valid_q;
	logic [1:0]       out_kind_q;
	logic [71:0]      out_data_q;

	logic [7:0]       ch;
	logic             at_end;
	logic             is_blank;
	logic             is_digit;
	logic [15:0]      val_next;
	logic [28:0]      prod;
	logic             busy;

	always_comb begin
		ch = 8'd0;
		for (int k = 0; k < CMD_DEPTH; k++) begin
			if (rd_q == IDX_W'(k)) ch = buf_q[k];
		end
	end

	// read position past the live text or on a zero byte ends the text
	assign at_end   = (rd_q >= idx_q) || (ch == 8'd0);
	assign is_blank = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
	assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign val_next = neg_q ? (16'd0 - acc_q) : acc_q;
	assign prod     = 29'(period_q) * 29'(CMP_SCALE);
	assign busy     = out_valid_q && !out_ready;

	always_comb begin
		flags.tick   = func_q;
		flags.colon  = (byte_q == CH_COLON);
		flags.not_cr = (byte_q != CH_CR);
		flags.at_end = at_end;
		flags.not_pt = (ch != CH_P) && (ch != CH_T);
		flags.blank  = !at_end && is_blank;
		flags.digit  = !at_end && is_digit;
		flags.busy   = busy;
	end

	// work registers, no reset needed
	always_ff @(posedge clk) begin
		if (start) begin
			func_q <= in_func;
			byte_q <= in_byte;
			rd_q   <= '0;
			acc_q  <= 16'd0;
			neg_q  <= 1'b0;
		end
		case (ctrl.op)
			OP_SELCMD: begin
				is_t_q <= (ch == CH_T);
				rd_q   <= rd_q + IDX_W'(1);
			end
			OP_SKIP: begin
				if (!at_end && is_blank) rd_q <= rd_q + IDX_W'(1);
			end
			OP_SIGN: begin
				if (!at_end && (ch == CH_PLUS || ch == CH_MINUS)) begin
					neg_q <= (ch == CH_MINUS);
					rd_q  <= rd_q + IDX_W'(1);
				end
			end
			OP_DIGIT: begin
				if (!at_end && is_digit) begin
					acc_q <= (acc_q << 3) + (acc_q << 1) + {12'd0, ch[3:0]};
					rd_q  <= rd_q + IDX_W'(1);
				end
			end
			OP_FINISH: begin
				val_q   <= val_next;
				ev_q    <= is_t_q ? EV_PERIOD : EV_TARGET;
				moved_q <= 1'b0;
			end
			OP_MULT: begin
				cmp_q <= is_t_q ? prod[15:0] : 16'd0;
			end
			OP_ERR: begin
				val_q   <= 16'd0;
				cmp_q   <= 16'd0;
				ev_q    <= EV_ERROR;
				moved_q <= 1'b0;
			end
			OP_TICK: begin
				val_q   <= 16'd0;
				cmp_q   <= 16'd0;
				ev_q    <= EV_TICK;
				moved_q <= (cur_q != tgt_q);
			end
			OP_STORE: begin
				if (idx_q < IDX_W'(CMD_DEPTH)) begin
					for (int k = 0; k < CMD_DEPTH; k++) begin
						if (idx_q == IDX_W'(k)) buf_q[k] <= byte_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			tgt_q    <= 16'd0;
			cur_q    <= 16'd0;
			period_q <= PERIOD_RST;
			step_q   <= 1'b0;
			dir_q    <= 1'b0;
		end else begin
			case (ctrl.op)
				OP_COLON: idx_q <= '0;
				OP_STORE: begin
					if (idx_q < IDX_W'(CMD_DEPTH)) idx_q <= idx_q + IDX_W'(1);
				end
				OP_FINISH: begin
					if (is_t_q) period_q <= val_next;
					else tgt_q <= val_next;
				end
				OP_TICK: begin
					if (cur_q != tgt_q) begin
						if ($signed(tgt_q) < $signed(cur_q)) begin
							dir_q <= 1'b0;
							cur_q <= cur_q - 16'd1;
						end else begin
							dir_q <= 1'b1;
							cur_q <= cur_q + 16'd1;
						end
						step_q <= ~step_q;
					end else begin
						step_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.op == OP_EMIT && !busy) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.op == OP_EMIT && !busy) begin
			out_kind_q <= ev_q;
			out_data_q <= {5'd0, moved_q, tgt_q, cur_q, dir_q, step_q, cmp_q, val_q};
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_data  = out_data_q;

	a_pos_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_q != $past(cur_q)) |->
		((cur_q - $past(cur_q)) == 16'd1 || (cur_q - $past(cur_q)) == 16'hFFFF))
		else $error("position moved by more than one step");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IDX_W'(CMD_DEPTH))
		else $error("command index past buffer depth");

	a_load_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(ctrl.op == OP_EMIT))
		else $error("output loaded outside emit step");

	a_moving_is_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q[66]) |-> out_kind_q == EV_TICK)
		else $error("moving flag on a non-tick transaction");

endmodule

`default_nettype wire

### rtl/serial_command_stepper_positioner.sv
// Top level of the serial command stepper positioner.
// Instantiates scsp_sequencer and scsp_datapath; depends on scsp_pkg.
//
// channel  | dir | handshake         | payload
// ---------+-----+-------------------+-------------------------------------------
// s_       | in  | s_tvalid/s_tready | s_tuser: func; s_tdata: rx_byte
// m_       | out | m_tvalid/m_tready | m_tuser: event_res; m_tdata: see port list
//
// Processing: after an item is accepted, s_tready stays low until the microprogram is back
// in its idle step; for a carriage return it parses the stored command (error exits sooner),
// walking the command buffer one character a step.
// Reset: asynchronous, clears index, positions, lines and sets the period to 1000.
// Stalls: the program waits in its emit step while the output register is still full.
`default_nettype none

module serial_command_stepper_positioner
	import scsp_pkg::*;
#(
	parameter int CMD_DEPTH = CMD_DEPTH_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] rx_byte
	input  wire  [0:0]  s_tuser,   // [0] func
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [71:0] m_tdata,   // [15:0] parsed_value, [31:16] compare_value,
	                               // [32] step_level, [33] direction, [49:34] position,
	                               // [65:50] goal, [66] moving, [71:67] zero
	output logic [1:0]  m_tuser    // [1:0] event_res
);

	scsp_ctrl_t  ctrl;
	scsp_flags_t flags;
	logic        start;

	assign s_tready = (ctrl.op == OP_IDLE);
	assign start    = s_tvalid && s_tready;

	scsp_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	scsp_datapath #(
		.CMD_DEPTH (CMD_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.in_func   (s_tuser[0]),
		.in_byte   (s_tdata),
		.ctrl      (ctrl),
		.flags     (flags),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_kind  (m_tuser),
		.out_data  (m_tdata)
	);

endmodule

`default_nettype wire

### tb/serial_command_stepper_positioner_test.sv
`timescale 1ns / 100ps
// Self-checking bench for serial_command_stepper_positioner: serial command text and timer
// ticks go in, each event/tick status coming out is checked against an in-bench predictor.
// Depends on scsp_pkg and the RTL top level only.

module serial_command_stepper_positioner_test;
	import scsp_pkg::*;

	localparam int          CMD_DEPTH   = CMD_DEPTH_DEF;
	localparam int unsigned CYCLE_LIMIT = 1000000;

	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_VT  = 8'h0B;
	localparam logic [7:0] CH_FF  = 8'h0C;
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_X   = 8'h58;

	localparam logic FN_BYTE = 1'b0;
	localparam logic FN_TICK = 1'b1;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] value;
		logic [15:0] compare;
		logic        step;
		logic        dir;
		logic [15:0] pos;
		logic [15:0] goal;
		logic        moving;
	} stepper_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic [1:0]  m_tuser;

	// predictor state
	logic [7:0]  cmd_text [CMD_DEPTH];
	int          cmd_fill;
	logic [15:0] pos_goal;
	logic [15:0] pos_now;
	logic [15:0] step_period;
	logic        step_out;
	logic        dir_out;

	stepper_result_t expected_results [$];
	int              mismatches = 0;
	int              items_sent = 0;
	int unsigned     cycle_count = 0;
	int              send_idle_pct = 20;
	int              sink_idle_pct = 66;

	serial_command_stepper_positioner i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("serial_command_stepper_positioner_test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_idle_pct);
	end

	// atoi-style parse of the stored text after the command letter, 16-bit wrap
	function automatic logic [15:0] parse_count(int len);
		int          i;
		logic [15:0] acc;
		logic        neg;
		i = 1;
		acc = '0;
		neg = 1'b0;
		while (i < len && (cmd_text[i] inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR}))
			i++;
		if (i < len && (cmd_text[i] == CH_PLUS || cmd_text[i] == CH_MINUS)) begin
			neg = (cmd_text[i] == CH_MINUS);
			i++;
		end
		while (i < len && cmd_text[i] >= CH_ZERO && cmd_text[i] <= CH_NINE) begin
			acc = 16'(acc * 16'd10 + 16'(cmd_text[i] - CH_ZERO));
			i++;
		end
		if (neg)
			acc = 16'(-acc);
		return acc;
	endfunction

	task automatic predict_item(input logic func_bit, input logic [7:0] ch);
		stepper_result_t r;
		logic            has_result;
		int              len;
		logic [31:0]     prod;
		r = '0;
		has_result = 1'b0;
		if (func_bit == FN_TICK) begin
			if (pos_now != pos_goal) begin
				if ($signed(pos_goal) < $signed(pos_now)) begin
					dir_out = 1'b0;
					pos_now = pos_now - 16'd1;
				end else begin
					dir_out = 1'b1;
					pos_now = pos_now + 16'd1;
				end
				step_out = ~step_out;
				r.moving = 1'b1;
			end else begin
				step_out = 1'b0;
			end
			r.kind = EV_TICK;
			has_result = 1'b1;
		end else if (ch == CH_COLON) begin
			cmd_fill = 0;
		end else if (ch != CH_CR) begin
			// bytes past a full buffer are dropped
			if (cmd_fill < CMD_DEPTH) begin
				cmd_text[cmd_fill] = ch;
				cmd_fill++;
			end
		end else begin
			// text ends at the index or at the first zero byte
			len = 0;
			while (len < cmd_fill && cmd_text[len] != CH_NUL)
				len++;
			r.kind = EV_ERROR;
			if (len >= 2 && cmd_text[0] == CH_P) begin
				r.value = parse_count(len);
				pos_goal = r.value;
				r.kind = EV_TARGET;
			end else if (len >= 2 && cmd_text[0] == CH_T) begin
				r.value = parse_count(len);
				step_period = r.value;
				prod = 32'(step_period) * 32'(CMP_SCALE);
				r.compare = prod[15:0];
				r.kind = EV_PERIOD;
			end
			has_result = 1'b1;
		end
		if (has_result) begin
			r.step = step_out;
			r.dir = dir_out;
			r.pos = pos_now;
			r.goal = pos_goal;
			expected_results.push_back(r);
		end
	endtask

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h expected %h", name, got, want));
	endtask

	always @(posedge clk) begin
		stepper_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result transaction with nothing expected");
			end else begin
				want = expected_results.pop_front();
				check_field("event_res", 16'(m_tuser), 16'(want.kind));
				check_field("parsed_value", m_tdata[15:0], want.value);
				check_field("compare_value", m_tdata[31:16], want.compare);
				check_field("step_level", 16'(m_tdata[32]), 16'(want.step));
				check_field("direction", 16'(m_tdata[33]), 16'(want.dir));
				check_field("position", m_tdata[49:34], want.pos);
				check_field("goal", m_tdata[65:50], want.goal);
				check_field("moving", 16'(m_tdata[66]), 16'(want.moving));
				check_field("pad", 16'(m_tdata[71:67]), 16'd0);
			end
		end
	end

	// entered and left at a rising edge; valid stays up between back-to-back items
	task automatic send_item(input logic func_bit, input logic [7:0] ch);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= func_bit;
		s_tdata <= ch;
		do
			@(posedge clk);
		while (!s_tready);
		predict_item(func_bit, ch);
		items_sent++;
	endtask

	task automatic send_text(input string text);
		for (int k = 0; k < text.len(); k++)
			send_item(FN_BYTE, text[k]);
	endtask

	task automatic test_tick_at_rest();
		// func set: the byte is ignored, position already at target
		send_item(FN_TICK, 8'hFF);
	endtask

	task automatic test_target_move();
		send_text(":P-3");
		send_item(FN_BYTE, CH_CR);
		repeat (4) send_item(FN_TICK, 8'h00);
	endtask

	task automatic test_period_set();
		send_text(":T+7");
		send_item(FN_BYTE, CH_CR);
	endtask

	task automatic test_bad_commands();
		send_item(FN_BYTE, CH_COLON);
		send_item(FN_BYTE, CH_CR);
		send_text(":P");
		send_item(FN_BYTE, CH_CR);
		send_text(":X5");
		send_item(FN_BYTE, CH_CR);
	endtask

	// one mostly well-formed command with random content
	task automatic send_command();
		logic [7:0]  text [$];
		string       digits;
		int unsigned v;
		int          pick;
		logic [7:0]  blanks [5];
		blanks = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF};
		if ($urandom_range(9) != 0)
			text.push_back(CH_COLON);
		pick = $urandom_range(19);
		if (pick == 0)
			text.push_back(8'($urandom_range(255)));
		else
			text.push_back(pick < 11 ? CH_P : CH_T);
		if ($urandom_range(3) == 0)
			repeat ($urandom_range(1, 2)) text.push_back(blanks[$urandom_range(4)]);
		pick = $urandom_range(5);
		if (pick == 0)
			text.push_back(CH_PLUS);
		else if (pick < 3)
			text.push_back(CH_MINUS);
		pick = $urandom_range(99);
		if (pick < 70)
			v = $urandom_range(40);
		else if (pick < 85)
			v = $urandom_range(99999);
		else if (pick < 92)
			v = 32767 + $urandom_range(1);
		else
			v = $urandom_range(999999999);
		digits = $sformatf("%0d", v);
		if ($urandom_range(19) != 0)
			for (int k = 0; k < digits.len(); k++)
				text.push_back(digits[k]);
		if ($urandom_range(9) == 0)
			text.push_back(8'($urandom_range(8'h21, 8'h7E)));
		if ($urandom_range(12) == 0)
			text.insert($urandom_range(text.size()), CH_NUL);
		foreach (text[k])
			send_item(FN_BYTE, text[k]);
		send_item(FN_BYTE, CH_CR);
	endtask

	task automatic test_random_traffic(input int n_items);
		int stop_at;
		int pick;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 60) begin
				send_command();
			end else if (pick < 85) begin
				repeat ($urandom_range(1, 8)) send_item(FN_TICK, 8'($urandom_range(255)));
			end else begin
				// noise: random bytes, stray CRs rerun whatever is stored
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(3) == 0)
						send_item(FN_BYTE, CH_CR);
					else
						send_item(FN_BYTE, 8'($urandom_range(255)));
				end
			end
		end
	endtask

	initial begin
		foreach (cmd_text[k])
			cmd_text[k] = '0;
		cmd_fill = 0;
		pos_goal = '0;
		pos_now = '0;
		step_period = PERIOD_RST;
		step_out = 1'b0;
		dir_out = 1'b0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 20;
		sink_idle_pct = 66;
		test_tick_at_rest();
		test_target_move();
		test_period_set();
		test_bad_commands();
		test_random_traffic(630);

		send_idle_pct = 66;
		sink_idle_pct = 20;
		test_random_traffic(650);

		send_idle_pct = 0;
		sink_idle_pct = 0;
		test_random_traffic(650);
		s_tvalid <= 1'b0;

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("serial_command_stepper_positioner_test passed");
		else
			$display("serial_command_stepper_positioner_test failed");
		$finish;
	end

endmodule

### serial_command_stepper_positioner.f
rtl/scsp_pkg.sv
rtl/scsp_sequencer.sv
rtl/scsp_datapath.sv
rtl/serial_command_stepper_positioner.sv
tb/serial_command_stepper_positioner_test.sv
